### design/radix_suffix_number_parser_assert.svh
// Assertion macros shared by the radix suffix number parser.
`ifndef RADIX_SUFFIX_NUMBER_PARSER_ASSERT_SVH
`define RADIX_SUFFIX_NUMBER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSNP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsnp same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsnp next-cycle check failed");

`endif

### design/rsnp_pkg.sv
// Shared types, character constants and lane helpers of the number parser.
`timescale 1ns / 1ps
package rsnp_pkg;

    localparam int LANES = 4;

    typedef logic [15:0] t_word;

    // Lane order: radix 16, 10, 8, 2
    typedef enum logic [1:0] {
        LANE_HEX = 2'd0,
        LANE_DEC = 2'd1,
        LANE_OCT = 2'd2,
        LANE_BIN = 2'd3
    } t_lane;

    localparam logic [4:0] LANE_RADIX [LANES] = '{5'd16, 5'd10, 5'd8, 5'd2};

    localparam logic [7:0] CASE_MASK   = 8'hDF;
    localparam logic [7:0] LOWER_LIMIT = 8'h60;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_Q        = 8'h51;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] DIGIT_MAX   = 8'd9;
    localparam logic [7:0] LETTER_GAP  = 8'd7;

    // Classified character, as handed from the front end to the lanes
    typedef struct packed {
        logic [7:0] digit;
        logic       bad_char;
        logic       last_char;
        logic       range_check_off;
        logic       suffix_hit;
        t_lane      suffix_lane;
    } t_cls;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_q_head;

    // Multiply a lane value by its radix, modulo 2^16, with shifts and adds
    function automatic t_word lane_scale(t_lane lane, t_word acc);
        t_word res;
        case (lane)
            LANE_HEX: res = {acc[11:0], 4'b0};
            LANE_DEC: res = {acc[12:0], 3'b0} + {acc[14:0], 1'b0};
            LANE_OCT: res = {acc[12:0], 3'b0};
            LANE_BIN: res = {acc[14:0], 1'b0};
            default:  res = acc;
        endcase
        return res;
    endfunction

endpackage

### design/rsnp_if.sv
// Handshake channels of the number parser: characters in, results out.
`timescale 1ns / 1ps
interface rsnp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       range_check_off;

    modport source (output valid, output char_code, output last_char,
                    output range_check_off, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input range_check_off, output ready);
endinterface

interface rsnp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic        illegal_digit;

    modport source (output valid, output value, output illegal_digit, input ready);
    modport sink   (input valid, input value, input illegal_digit, output ready);
endinterface

### design/rsnp_front.sv
// Front end: takes characters, upper-cases and classifies them for the queue.
`timescale 1ns / 1ps
module rsnp_front
    import rsnp_pkg::*;
(
    rsnp_char_if.sink i_char_if,
    input  logic      i_q_full,
    output logic      o_push,
    output t_cls      o_cls
);

    logic [7:0] up_char;
    logic [7:0] raw_digit;

    // Accept whenever the queue has room
    assign i_char_if.ready = !i_q_full;
    assign o_push          = i_char_if.valid && !i_q_full;

    // Fold case, derive the digit value and decode a possible radix suffix
    always_comb begin
        up_char   = (i_char_if.char_code > LOWER_LIMIT) ? (i_char_if.char_code & CASE_MASK)
                                                        : i_char_if.char_code;
        raw_digit = up_char - CH_ZERO;
        o_cls.digit           = (raw_digit > DIGIT_MAX) ? (raw_digit - LETTER_GAP) : raw_digit;
        o_cls.bad_char        = (up_char == CH_QMARK) || (up_char == CH_AT);
        o_cls.last_char       = i_char_if.last_char;
        o_cls.range_check_off = i_char_if.range_check_off;

        o_cls.suffix_hit  = 1'b1;
        o_cls.suffix_lane = LANE_DEC;
        case (up_char)
            CH_H: o_cls.suffix_lane = LANE_HEX;
            CH_D: o_cls.suffix_lane = LANE_DEC;
            CH_O: o_cls.suffix_lane = LANE_OCT;
            CH_Q: o_cls.suffix_lane = LANE_OCT;
            CH_B: o_cls.suffix_lane = LANE_BIN;
            default: o_cls.suffix_hit = 1'b0;
        endcase
    end

endmodule

### design/rsnp_queue.sv
// Short queue of classified characters between front and back ends.
`timescale 1ns / 1ps
module rsnp_queue
    import rsnp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cls    i_cls,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cls   = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

### design/rsnp_back.sv
// Back end: four radix lanes, suffix selection and the result register.
`timescale 1ns / 1ps
module rsnp_back
    import rsnp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q_head      i_head,
    output logic         o_ready,
    rsnp_res_if.source   o_res_if
);

    t_word      r_accum [LANES];
    t_word      n_accum [LANES];
    logic [3:0] r_err, n_err;
    logic       r_out_valid;
    t_word      r_out_value, n_out_value;
    logic       r_out_illegal, n_out_illegal;
    logic       pop;
    logic       pop_last;

    // A final character needs a free result slot
    assign o_ready  = !i_head.cls.last_char || !r_out_valid || o_res_if.ready;
    assign pop      = i_head.valid && o_ready;
    assign pop_last = pop && i_head.cls.last_char;

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.value         = r_out_value;
    assign o_res_if.illegal_digit = r_out_illegal;

    // Scale each lane and add its digit, or zero when out of range or a bad character
    always_comb begin
        logic       over;
        logic       flag;
        logic [7:0] lane_digit;
        for (int k = 0; k < LANES; k++) begin
            over       = (i_head.cls.digit >= {3'b0, LANE_RADIX[k]})
                         && !i_head.cls.range_check_off;
            flag       = i_head.cls.bad_char || over;
            lane_digit = flag ? 8'd0 : i_head.cls.digit;
            n_accum[k] = lane_scale(t_lane'(k), r_accum[k]) + {8'b0, lane_digit};
            n_err[k]   = r_err[k] | flag;
        end
    end

    // Pick the pre-suffix snapshot or the updated decimal lane
    always_comb begin
        if (i_head.cls.suffix_hit) begin
            n_out_value   = r_accum[i_head.cls.suffix_lane];
            n_out_illegal = r_err[i_head.cls.suffix_lane];
        end else begin
            n_out_value   = n_accum[LANE_DEC];
            n_out_illegal = n_err[LANE_DEC];
        end
    end

    // Update lanes; clear them after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_accum[k] <= '0;
            end
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_last) begin
                for (int k = 0; k < LANES; k++) begin
                    r_accum[k] <= '0;
                end
                r_err <= '0;
            end else if (pop) begin
                for (int k = 0; k < LANES; k++) begin
                    r_accum[k] <= n_accum[k];
                end
                r_err <= n_err;
            end
            if (pop_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (pop_last) begin
            r_out_value   <= n_out_value;
            r_out_illegal <= n_out_illegal;
        end
    end

endmodule

### design/radix_suffix_number_parser.sv
// Path: the final character is written into the queue and, once the result
// slot is free or being taken, popped into the result register.
// Throughput: one character per cycle while the sink is ready; the result
// slot frees the same cycle it is taken, so tokens stream without gaps.
// Reset: synchronous, active low; clears lanes, queue and the result register.
// Top level of the radix suffix number parser.
`timescale 1ns / 1ps
module radix_suffix_number_parser
    import rsnp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsnp_char_if.sink    i_char_if,
    rsnp_res_if.source   o_res_if
);

    `include "radix_suffix_number_parser_assert.svh"

    logic    q_full;
    logic    push;
    t_cls    front_cls;
    t_q_head q_head;
    logic    back_ready;
    logic    pop;
    logic    pop_last;

    assign pop      = q_head.valid && back_ready;
    assign pop_last = pop && q_head.cls.last_char;

    // Classify incoming characters
    rsnp_front u_front (
        .i_char_if (i_char_if),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cls     (front_cls)
    );

    // Decouple front and back
    rsnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // Accumulate and produce results
    rsnp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .o_ready  (back_ready),
        .o_res_if (o_res_if)
    );

    // Checks
    `RSNP_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, push, !q_full)
    `RSNP_ASSERT_SAME(a_pop_needs_entry, i_clk, i_rst_n, pop, q_head.valid)
    `RSNP_ASSERT_NEXT(a_result_after_last, i_clk, i_rst_n, pop_last, o_res_if.valid)

endmodule
